// ===== design/wact_pkg.sv =====
// wact_pkg: types and constants for the window actuator sequencer
// no dependencies; imported by window_actuator_sequencer_top
`timescale 1ns / 1ps
`default_nettype none

package wact_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_CLOSE   = 3'd0,
        PH_CLOSING = 3'd1,
        PH_CLOSED  = 3'd2,
        PH_OPEN    = 3'd3,
        PH_OPENING = 3'd4,
        PH_OPENED  = 3'd5
    } phase_t;

    // servo drive state
    typedef enum logic [1:0] {
        DRV_OFF   = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } drive_t;

    // item commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CLICK = 2'd1,
        CMD_HOLD  = 2'd2,
        CMD_SET   = 2'd3
    } cmd_t;

    // lamp modes
    localparam logic [1:0] LAMP_OFF  = 2'd0;
    localparam logic [1:0] LAMP_SLOW = 2'd1;
    localparam logic [1:0] LAMP_FAST = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TASK_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SAFETY_CLOSE = 3'd1;
    localparam logic [2:0] REG_CLICK_OPEN   = 3'd2;
    localparam logic [2:0] REG_HOLD_OPEN    = 3'd3;
    localparam logic [2:0] REG_OPEN_ANGLE   = 3'd4;
    localparam logic [2:0] REG_CLOSE_ANGLE  = 3'd5;

    // register reset values
    localparam logic [7:0]  TASK_PERIOD_RST  = 8'd20;
    localparam logic [15:0] SAFETY_CLOSE_RST = 16'd5000;
    localparam logic [14:0] CLICK_OPEN_RST   = 15'd2000;
    localparam logic [14:0] HOLD_OPEN_RST    = 15'd4000;
    localparam logic [7:0]  OPEN_ANGLE_RST   = 8'd110;
    localparam logic [7:0]  CLOSE_ANGLE_RST  = 8'd70;

    // milliseconds per tenth of a second, closing time ceiling
    localparam logic [14:0] TENTH_MS    = 15'd100;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ===== design/window_actuator_sequencer_top.sv =====
// window_actuator_sequencer_top: six-phase window actuator sequencer
// depends on wact_pkg (phase, drive and command codes, register indexes)
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  s_      | s_valid / s_ready  | cmd, open_tenths, end_stop_closed
//  m_      | m_valid / m_ready  | drive and lamp state, reports, duration, phase
//  cfg_    | cfg_wr_en          | cfg_index, cfg_wdata (16 bit, no read-back)
//
// one item per cycle: an accepted item updates the state and loads the result
// register at the same edge; its result shows in the cycle after.
// s_ready is high while the result register is empty or being taken, so a new
// item enters in the cycle its predecessor's result leaves.
// a stall on m_ready holds the result and stops intake; no other wait.
// aresetn is synchronous, active low; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module window_actuator_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_open_tenths,
    input  wire logic        s_end_stop_closed,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_drive_enable,
    output logic [7:0]       m_drive_angle,
    output logic [1:0]       m_lamp_mode,
    output logic             m_report_closed,
    output logic             m_report_safety_stop,
    output logic             m_report_opened,
    output logic [14:0]      m_opened_duration_ms,
    output logic [2:0]       m_phase_now
);
    import wact_pkg::*;

    // configuration registers
    logic [7:0]  task_period_reg;
    logic [15:0] safety_close_reg;
    logic [14:0] click_open_reg;
    logic [14:0] hold_open_reg;
    logic [7:0]  open_angle_reg;
    logic [7:0]  close_angle_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    drive_t      drive_reg, drive_next;
    logic [14:0] open_dur_reg, open_dur_next;
    logic [14:0] wait_reg, wait_next;
    logic [16:0] elapsed_reg, elapsed_next;

    // result register
    logic        m_valid_reg;
    logic        enable_reg;
    logic [7:0]  angle_reg;
    logic [1:0]  lamp_reg;
    logic        rep_closed_reg, rep_closed_next;
    logic        rep_safety_reg, rep_safety_next;
    logic        rep_opened_reg, rep_opened_next;
    logic [14:0] dur_out_reg;
    logic [2:0]  phase_out_reg;

    logic        accept;
    logic [14:0] wait_dec;
    logic [14:0] set_dur;
    logic [7:0]  angle_next;
    logic [1:0]  lamp_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_period_reg  <= TASK_PERIOD_RST;
            safety_close_reg <= SAFETY_CLOSE_RST;
            click_open_reg   <= CLICK_OPEN_RST;
            hold_open_reg    <= HOLD_OPEN_RST;
            open_angle_reg   <= OPEN_ANGLE_RST;
            close_angle_reg  <= CLOSE_ANGLE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TASK_PERIOD:  task_period_reg  <= cfg_wdata[7:0];
                REG_SAFETY_CLOSE: safety_close_reg <= cfg_wdata;
                REG_CLICK_OPEN:   click_open_reg   <= cfg_wdata[14:0];
                REG_HOLD_OPEN:    hold_open_reg    <= cfg_wdata[14:0];
                REG_OPEN_ANGLE:   open_angle_reg   <= cfg_wdata[7:0];
                REG_CLOSE_ANGLE:  close_angle_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // radio duration: tenths times 100 stays below 2^15
    assign set_dur  = 15'({7'd0, s_open_tenths} * TENTH_MS);
    assign wait_dec = (wait_reg != 15'd0) ? wait_reg - 15'd1 : 15'd0;

    // next state for one item
    always_comb begin
        phase_next      = phase_reg;
        drive_next      = drive_reg;
        open_dur_next   = open_dur_reg;
        wait_next       = wait_reg;
        elapsed_next    = elapsed_reg;
        rep_closed_next = 1'b0;
        rep_safety_next = 1'b0;
        rep_opened_next = 1'b0;
        case (cmd_t'(s_cmd))
            CMD_TICK: begin
                if (phase_reg == PH_CLOSING && elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 17'd1;
                end
                wait_next = wait_dec;
                // phase step once the wait runs out
                if (wait_dec == 15'd0) begin
                    wait_next = {7'd0, task_period_reg};
                    case (phase_reg)
                        PH_CLOSE: begin
                            drive_next   = DRV_CLOSE;
                            elapsed_next = 17'd0;
                            phase_next   = PH_CLOSING;
                        end
                        PH_CLOSING: begin
                            if (s_end_stop_closed) begin
                                drive_next      = DRV_OFF;
                                rep_closed_next = 1'b1;
                                phase_next      = PH_CLOSED;
                            end
                            if (elapsed_next > {1'b0, safety_close_reg}) begin
                                drive_next      = DRV_OFF;
                                rep_safety_next = 1'b1;
                                phase_next      = PH_CLOSED;
                            end
                        end
                        PH_CLOSED: begin
                            if (open_dur_reg != 15'd0) phase_next = PH_OPEN;
                        end
                        PH_OPEN: begin
                            drive_next = DRV_OPEN;
                            phase_next = PH_OPENING;
                            wait_next  = open_dur_reg;
                        end
                        PH_OPENING: begin
                            rep_opened_next = 1'b1;
                            phase_next      = PH_OPENED;
                        end
                        PH_OPENED: begin
                            drive_next = DRV_OFF;
                            if (open_dur_reg == 15'd0) phase_next = PH_CLOSE;
                        end
                        default: phase_next = PH_CLOSE;
                    endcase
                end
            end
            CMD_CLICK: begin
                if (phase_reg == PH_CLOSED) begin
                    open_dur_next = click_open_reg;
                end else if (phase_reg == PH_OPENED) begin
                    open_dur_next = 15'd0;
                end
            end
            CMD_HOLD: begin
                if (phase_reg == PH_CLOSED) open_dur_next = hold_open_reg;
            end
            default: open_dur_next = set_dur;
        endcase
    end

    // drive and lamp view of the new drive state
    always_comb begin
        case (drive_next)
            DRV_OPEN: begin
                angle_next = open_angle_reg;
                lamp_next  = LAMP_FAST;
            end
            DRV_CLOSE: begin
                angle_next = close_angle_reg;
                lamp_next  = LAMP_SLOW;
            end
            default: begin
                angle_next = 8'd0;
                lamp_next  = LAMP_OFF;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CLOSE;
            drive_reg    <= DRV_OFF;
            open_dur_reg <= 15'd0;
            wait_reg     <= 15'd0;
            elapsed_reg  <= 17'd0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            drive_reg    <= drive_next;
            open_dur_reg <= open_dur_next;
            wait_reg     <= wait_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            enable_reg     <= (drive_next != DRV_OFF);
            angle_reg      <= angle_next;
            lamp_reg       <= lamp_next;
            rep_closed_reg <= rep_closed_next;
            rep_safety_reg <= rep_safety_next;
            rep_opened_reg <= rep_opened_next;
            dur_out_reg    <= open_dur_next;
            phase_out_reg  <= phase_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_drive_enable       = enable_reg;
    assign m_drive_angle        = angle_reg;
    assign m_lamp_mode          = lamp_reg;
    assign m_report_closed      = rep_closed_reg;
    assign m_report_safety_stop = rep_safety_reg;
    assign m_report_opened      = rep_opened_reg;
    assign m_opened_duration_ms = dur_out_reg;
    assign m_phase_now          = phase_out_reg;

`ifndef NO_ASSERTIONS
    // a closing report leaves the drive off in the closed phase
    a_close_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_report_closed || m_report_safety_stop) |->
            !m_drive_enable && m_phase_now == PH_CLOSED)
        else $error("closing report without closed phase and drive off");

    // the opened report lands in the opened phase with the drive still open
    a_open_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_opened |->
            m_phase_now == PH_OPENED && m_lamp_mode == LAMP_FAST)
        else $error("opened report outside opened phase");

    // lamp and drive enable agree
    a_lamp_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_enable == (m_lamp_mode != LAMP_OFF)))
        else $error("lamp mode disagrees with drive enable");

    // a result that is not taken stays in place
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase_now)
            && $stable(m_opened_duration_ms))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
